// File: rtl/brle_pkg.sv
package brle_pkg;

   localparam int unsigned ValueWidth  = 8;
   localparam int unsigned CountWidth  = 17;
   localparam int unsigned EncWidth    = 18;
   localparam int unsigned RepWidth    = 16;
   localparam int unsigned QueueDepth  = 4;
   localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

   localparam logic [ValueWidth-1:0] RunMax = 8'd255;
   localparam logic [RepWidth-1:0]   RepMax = 16'hFFFF;

   // one emitted (value, length) pair with the end-of-stream totals
   typedef struct packed {
      logic [ValueWidth-1:0] run_value;
      logic [ValueWidth-1:0] run_length;
      logic                  end_of_stream;
      logic [CountWidth-1:0] total_bytes;
      logic [EncWidth-1:0]   encoded_bytes;
      logic [RepWidth-1:0]   repeat_pairs;
      logic                  rle_suitable;
   } pair_type;

   // pairs produced by one accepted byte, in emission order
   typedef struct packed {
      logic [1:0] count;
      pair_type   first;
      pair_type   second;
   } push_type;

endpackage

// File: rtl/brle_core.sv
module brle_core #(
   parameter logic [16:0] CNT_LIMIT = 17'd65536
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [brle_pkg::ValueWidth-1:0] data_byte,
   input  logic                         last_byte,
   output brle_pkg::push_type           push
);

   logic                                run_open_ff;
   logic [brle_pkg::ValueWidth-1:0]     value_ff;
   logic [brle_pkg::ValueWidth-1:0]     length_ff;
   logic [brle_pkg::RepWidth-1:0]       repeat_ff;
   logic [brle_pkg::CountWidth-1:0]     bytes_ff;
   logic [brle_pkg::CountWidth-1:0]     runs_ff;

   logic                                run_open_in;
   logic [brle_pkg::ValueWidth-1:0]     value_in;
   logic [brle_pkg::ValueWidth-1:0]     length_in;
   logic [brle_pkg::RepWidth-1:0]       repeat_in;
   logic [brle_pkg::CountWidth-1:0]     bytes_in;
   logic [brle_pkg::CountWidth-1:0]     runs_in;

   logic                                same;
   logic                                emit_mid;
   logic [brle_pkg::ValueWidth-1:0]     len_upd;
   logic [brle_pkg::RepWidth-1:0]       rep_upd;
   logic [brle_pkg::CountWidth-1:0]     bytes_upd;
   logic [brle_pkg::CountWidth-1:0]     runs_mid;
   logic [brle_pkg::CountWidth-1:0]     runs_fin;
   logic [brle_pkg::RepWidth+2:0]       rep_x5;
   brle_pkg::pair_type                  mid_pair;
   brle_pkg::pair_type                  fin_pair;

   always_comb begin
      same      = run_open_ff && (data_byte == value_ff);
      emit_mid  = run_open_ff && (!same || (length_ff == brle_pkg::RunMax));
      bytes_upd = (bytes_ff < CNT_LIMIT) ? bytes_ff + 1'b1 : bytes_ff;
      rep_upd   = (same && (repeat_ff != brle_pkg::RepMax)) ? repeat_ff + 1'b1 : repeat_ff;
      runs_mid  = (emit_mid && (runs_ff < CNT_LIMIT)) ? runs_ff + 1'b1 : runs_ff;
      runs_fin  = (runs_mid < CNT_LIMIT) ? runs_mid + 1'b1 : runs_mid;
      len_upd   = (same && (length_ff != brle_pkg::RunMax)) ? length_ff + 1'b1 : 8'd1;
      // repeats times five, as shift and add
      rep_x5    = {1'b0, rep_upd, 2'b00} + {3'b000, rep_upd};

      mid_pair               = '0;
      mid_pair.run_value     = value_ff;
      mid_pair.run_length    = length_ff;

      fin_pair               = '0;
      fin_pair.run_value     = data_byte;
      fin_pair.run_length    = len_upd;
      fin_pair.end_of_stream = 1'b1;
      fin_pair.total_bytes   = bytes_upd;
      fin_pair.encoded_bytes = {runs_fin, 1'b0};
      fin_pair.repeat_pairs  = rep_upd;
      fin_pair.rle_suitable  = rep_x5 > {2'b00, bytes_upd};

      push.count  = accept ? ({1'b0, emit_mid} + {1'b0, last_byte}) : 2'd0;
      push.first  = emit_mid ? mid_pair : fin_pair;
      push.second = fin_pair;

      if (last_byte) begin
         // stream done, back to the idle state
         run_open_in = 1'b0;
         value_in    = '0;
         length_in   = '0;
         repeat_in   = '0;
         bytes_in    = '0;
         runs_in     = '0;
      end else begin
         run_open_in = 1'b1;
         value_in    = data_byte;
         length_in   = len_upd;
         repeat_in   = rep_upd;
         bytes_in    = bytes_upd;
         runs_in     = runs_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff <= 1'b0;
         value_ff    <= '0;
         length_ff   <= '0;
         repeat_ff   <= '0;
         bytes_ff    <= '0;
         runs_ff     <= '0;
      end else if (accept) begin
         run_open_ff <= run_open_in;
         value_ff    <= value_in;
         length_ff   <= length_in;
         repeat_ff   <= repeat_in;
         bytes_ff    <= bytes_in;
         runs_ff     <= runs_in;
      end
   end

endmodule

// File: rtl/brle_queue.sv
module brle_queue (
   input  logic                clock,
   input  logic                reset,
   input  brle_pkg::push_type  push,
   output logic                room,
   output logic                out_valid,
   output brle_pkg::pair_type  out_pair,
   input  logic                out_ready
);

   brle_pkg::pair_type                 entry_ff [brle_pkg::QueueDepth];
   brle_pkg::pair_type                 entry_in [brle_pkg::QueueDepth];
   logic [brle_pkg::QueueCntW-1:0]     count_ff;
   logic [brle_pkg::QueueCntW-1:0]     count_in;
   logic [brle_pkg::QueueCntW-1:0]     base;
   logic                               pop;

   // head sits at entry 0, pops shift the rest down
   always_comb begin
      pop       = out_valid && out_ready;
      base      = count_ff - {{(brle_pkg::QueueCntW-1){1'b0}}, pop};
      count_in  = base + {{(brle_pkg::QueueCntW-2){1'b0}}, push.count};
      for (int i = 0; i < brle_pkg::QueueDepth; i++) begin
         if ((push.count != 2'd0) && (base == brle_pkg::QueueCntW'(i))) begin
            entry_in[i] = push.first;
         end else if ((push.count == 2'd2) && (base + 1'b1 == brle_pkg::QueueCntW'(i))) begin
            entry_in[i] = push.second;
         end else if (pop && (i < brle_pkg::QueueDepth - 1)) begin
            entry_in[i] = entry_ff[(i + 1) % brle_pkg::QueueDepth];
         end else begin
            entry_in[i] = entry_ff[i];
         end
      end
   end

   assign room      = count_ff <= brle_pkg::QueueCntW'(brle_pkg::QueueDepth - 2);
   assign out_valid = count_ff != '0;
   assign out_pair  = entry_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < brle_pkg::QueueDepth; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

endmodule

// File: rtl/byte_run_length_encoder_unit.sv
// channel   dir  tdata                                          tlast          tuser
// req_      in   [7:0] data_byte                                last_byte      -
// rsp_      out  [7:0] run_value, [15:8] run_length,            end_of_stream  -
//                [32:16] total_bytes, [50:33] encoded_bytes,
//                [66:51] repeat_pairs, [67] rle_suitable
//
// one byte per cycle while req_tready is high; run update and pair build are one
// compare-and-increment step feeding a registered 4-entry queue that drives rsp_
// a closing byte can yield two pairs, but a stream never has more pairs than
// bytes, so with rsp_tready high at most two wait and req_tready stays high
// req_tready drops while three or more pairs wait, so only rsp_ stalls block it
// synchronous active-high reset empties the queue and clears the open run
module byte_run_length_encoder_unit #(
   parameter longint unsigned MAX_STREAM_LEN = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // run_value, run_length, total_bytes,
                                    // encoded_bytes, repeat_pairs, rle_suitable, zero pad
   output logic        rsp_tlast    // end_of_stream
);

   // counters hold 17 bits, so the limit is capped to what they can count
   localparam logic [16:0] CntLimit =
      (MAX_STREAM_LEN > 64'd131071) ? 17'h1FFFF : MAX_STREAM_LEN[16:0];

   logic                accept;
   brle_pkg::push_type  push;
   brle_pkg::pair_type  head;

   assign accept = req_tvalid && req_tready;

   // run tracking and pair building
   brle_core #(
      .CNT_LIMIT (CntLimit)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .push      (push)
   );

   // result beats wait here until taken
   brle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (req_tready),
      .out_valid (rsp_tvalid),
      .out_pair  (head),
      .out_ready (rsp_tready)
   );

   // pack result beat, first field in the low bits
   assign rsp_tdata = {4'b0000, head.rle_suitable, head.repeat_pairs, head.encoded_bytes,
                       head.total_bytes, head.run_length, head.run_value};
   assign rsp_tlast = head.end_of_stream;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   // byte count and run count stop at this limit, tied to the block's parameter
   localparam longint unsigned StreamCap = 65536;
   // cycles with nothing accepted while work is outstanding before giving up
   localparam int unsigned StallLimit = 2000;

   // one raw input beat as queued for the driver
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } raw_byte_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] data_byte
   logic        req_tlast = 1'b0; // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // [7:0] run_value, [15:8] run_length, [32:16] total_bytes,
                                  // [50:33] encoded_bytes, [66:51] repeat_pairs,
                                  // [67] rle_suitable, [71:68] zero pad
   logic        rsp_tlast;        // end_of_stream

   byte_run_length_encoder_unit #(
      .MAX_STREAM_LEN(StreamCap)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // stimulus and expectation stores
   raw_byte_type       raw_bytes[$];
   brle_pkg::pair_type pairs_due[$];
   raw_byte_type       next_beat;

   // idle rates in percent, changed per phase
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   // bookkeeping
   int unsigned error_count    = 0;
   int unsigned bytes_queued   = 0;
   int unsigned bytes_accepted = 0;
   int unsigned pairs_checked  = 0;
   int unsigned streams_closed = 0;
   int unsigned idle_cycles    = 0;

   // encoder state as the predictor sees it
   logic        run_open   = 1'b0;
   logic [7:0]  run_byte   = '0;
   logic [7:0]  run_len    = '0;
   logic [15:0] repeats    = '0;
   logic [16:0] byte_total = '0;
   logic [16:0] run_total  = '0;

   task automatic report_mismatch(input string what, input longint unsigned want,
                                  input longint unsigned got);
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      error_count++;
   endtask

   task automatic count_run();
      if (run_total < StreamCap) run_total++;
   endtask

   // queue one expected pair; totals only travel on the closing pair
   task automatic push_pair(input logic [7:0] value, input logic [7:0] length,
                            input logic closing);
      brle_pkg::pair_type p;
      p = '0;
      p.run_value     = value;
      p.run_length    = length;
      p.end_of_stream = closing;
      if (closing) begin
         p.total_bytes   = byte_total;
         p.encoded_bytes = {run_total, 1'b0};
         p.repeat_pairs  = repeats;
         p.rle_suitable  = (int'(repeats) * 5 > int'(byte_total));
      end
      pairs_due.insert(pairs_due.size(), p);
   endtask

   // advance the predicted encoder by one accepted byte
   task automatic encode_byte(input logic [7:0] b, input logic is_last);
      if (byte_total < StreamCap) byte_total++;
      if (run_open && b == run_byte) begin
         if (repeats != brle_pkg::RepMax) repeats++;
         if (run_len != brle_pkg::RunMax) begin
            run_len++;
         end else begin
            // full run goes out, the equal byte starts a fresh one
            count_run();
            push_pair(run_byte, run_len, 1'b0);
            run_len = 8'd1;
         end
      end else begin
         if (run_open) begin
            count_run();
            push_pair(run_byte, run_len, 1'b0);
         end
         run_open = 1'b1;
         run_byte = b;
         run_len  = 8'd1;
      end
      if (is_last) begin
         count_run();
         push_pair(run_byte, run_len, 1'b1);
         run_open   = 1'b0;
         run_byte   = '0;
         run_len    = '0;
         repeats    = '0;
         byte_total = '0;
         run_total  = '0;
      end
   endtask

   task automatic add_byte(input logic [7:0] value, input logic is_last);
      raw_byte_type beat;
      beat.data = value;
      beat.last = is_last;
      raw_bytes.insert(raw_bytes.size(), beat);
      bytes_queued++;
   endtask

   task automatic add_run(input logic [7:0] value, input int count, input logic ends);
      for (int i = 1; i <= count; i++) add_byte(value, ends && i == count);
   endtask

   // a stream of runs with random values; a run may repeat the previous value
   task automatic add_stream(input int length, input int longest_run);
      int left;
      int run;
      logic [7:0] value;
      left  = length;
      value = 8'($urandom_range(255));
      while (left > 0) begin
         if ($urandom_range(3) != 0) value = 8'($urandom_range(255));
         run = int'($urandom_range(longest_run, 1));
         if (run > left) run = left;
         repeat (run) begin
            left--;
            add_byte(value, left == 0);
         end
      end
   endtask

   // set the idle mix, queue random streams, then let everything drain
   task automatic run_phase(input int unsigned send_idle, input int unsigned stall,
                            input int unsigned random_bytes);
      int unsigned goal;
      int unsigned pick;
      send_idle_pct = send_idle;
      rsp_stall_pct = stall;
      goal = bytes_queued + random_bytes;
      while (bytes_queued < goal) begin
         pick = $urandom_range(19);
         if (pick == 0) add_stream(int'($urandom_range(120, 40)), 60);
         else if (pick < 5) add_stream(int'($urandom_range(4, 1)), 3);
         else if (pick < 11) add_stream(int'($urandom_range(40, 5)), 1);
         else add_stream(int'($urandom_range(60, 5)), 8);
      end
      while (raw_bytes.size() != 0 || req_tvalid || pairs_due.size() != 0)
         @(posedge clock);
   endtask

   // input driver: predicts on every accepted beat, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            encode_byte(req_tdata, req_tlast);
            bytes_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (raw_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_beat = raw_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_beat.data;
               req_tlast  <= next_beat.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor: each accepted beat against the oldest expected pair
   always @(posedge clock) begin : result_monitor
      brle_pkg::pair_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pairs_due.size() == 0) begin
               report_mismatch("result beat with nothing expected, run_value", 64'd0,
                               64'(rsp_tdata[7:0]));
            end else begin
               want = pairs_due.pop_front();
               pairs_checked++;
               if (rsp_tdata[7:0] !== want.run_value)
                  report_mismatch("run_value", 64'(want.run_value), 64'(rsp_tdata[7:0]));
               if (rsp_tdata[15:8] !== want.run_length)
                  report_mismatch("run_length", 64'(want.run_length), 64'(rsp_tdata[15:8]));
               if (rsp_tlast !== want.end_of_stream)
                  report_mismatch("end_of_stream", 64'(want.end_of_stream), 64'(rsp_tlast));
               if (rsp_tdata[32:16] !== want.total_bytes)
                  report_mismatch("total_bytes", 64'(want.total_bytes),
                                  64'(rsp_tdata[32:16]));
               if (rsp_tdata[50:33] !== want.encoded_bytes)
                  report_mismatch("encoded_bytes", 64'(want.encoded_bytes),
                                  64'(rsp_tdata[50:33]));
               if (rsp_tdata[66:51] !== want.repeat_pairs)
                  report_mismatch("repeat_pairs", 64'(want.repeat_pairs),
                                  64'(rsp_tdata[66:51]));
               if (rsp_tdata[67] !== want.rle_suitable)
                  report_mismatch("rle_suitable", 64'(want.rle_suitable), 64'(rsp_tdata[67]));
               if (want.end_of_stream) streams_closed++;
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // watchdog: only counts while work is outstanding and neither side moves
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (raw_bytes.size() == 0 && !req_tvalid && pairs_due.size() == 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("timeout: no beat moved for %0d cycles", idle_cycles);
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // single-byte streams at both value extremes
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b1);
      // pairs of extremes, last byte differs so it yields two pairs
      add_run(8'hFF, 2, 1'b0);
      add_run(8'h00, 2, 1'b0);
      add_byte(8'h5A, 1'b0);
      add_byte(8'hA5, 1'b1);
      // last byte extends the open run
      add_run(8'h33, 3, 1'b1);
      add_byte(8'h80, 1'b0);
      add_byte(8'h01, 1'b1);

      // run length limit: the last byte finds a full run, so it emits it and closes a new one
      add_run(8'h3C, 256, 1'b1);

      run_phase(0, 0, 110);
      run_phase(70, 0, 110);
      run_phase(0, 70, 110);
      run_phase(20, 20, 110);

      // let any stray result beat show up
      repeat (20) @(posedge clock);

      $display("run covered %0d bytes in %0d streams, %0d pairs checked", bytes_accepted,
               streams_closed, pairs_checked);
      $display("phases: free flow, sender gaps, receiver stalls, both; %0d mismatches",
               error_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/brle_pkg.sv
rtl/brle_core.sv
rtl/brle_queue.sv
rtl/byte_run_length_encoder_unit.sv
bench/testbench.sv
